[hdl/assert_macros.svh]
// Assertion helpers used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a in this cycle implies b in this cycle
`define MRHM_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle implication failed");

// a in this cycle implies b in the next cycle
`define MRHM_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle implication failed");

// a never holds
`define MRHM_ASSERT_NEVER(lbl, clk, rst, a) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("forbidden condition seen");

`endif

[hdl/mrhm_pkg.sv]
package mrhm_pkg;

   localparam int MAX_REPORT_BYTES_DEF = 64;
   localparam int MIN_REPORT_BYTES     = 9;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLAVE_ADDRESS      = 2'd0,
      CSR_OUTBOUND_REPORT_ID = 2'd1,
      CSR_INBOUND_REPORT_ID  = 2'd2,
      CSR_REPORT_SIZE        = 2'd3
   } csr_index_type;

   localparam logic [7:0] SLAVE_ADDRESS_RST      = 8'd1;
   localparam logic [7:0] OUTBOUND_REPORT_ID_RST = 8'h90;
   localparam logic [7:0] INBOUND_REPORT_ID_RST  = 8'h89;
   localparam logic [6:0] REPORT_SIZE_RST        = 7'd64;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
   localparam int          EXCEPTION_BIT   = 7;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_OUT_BYTE = 2'd0,
      KIND_REG_WORD = 2'd1,
      KIND_COMPLETE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXCEPTION = 2'd1,
      STATUS_WRONG_ID  = 2'd2,
      STATUS_COUNT_BAD = 2'd3
   } status_type;

   typedef struct packed {
      logic       command;
      logic       first_of_report;
      logic [7:0] data_byte;
      logic [15:0] start_address;
      logic [6:0] register_count;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic [6:0]  register_index;
      status_type  status;
      logic        last;
   } rsp_item_type;

   // outbound report sequencer towards the top level
   typedef struct packed {
      logic       busy;
      logic [7:0] data;
      logic       last;
   } gen_out_type;

   // response parser results for the byte being stepped
   typedef struct packed {
      logic        word;
      logic [15:0] word_value;
      logic [6:0]  word_index;
      logic        done;
      status_type  done_status;
      logic [15:0] done_value;
   } parse_out_type;

endpackage

[hdl/mrhm_ifs.sv]
interface mrhm_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic        first_of_report;
   logic [7:0]  data_byte;
   logic [15:0] start_address;
   logic [6:0]  register_count;

   modport source (output valid, command, first_of_report, data_byte, start_address,
                   register_count, input ready);
   modport sink   (input valid, command, first_of_report, data_byte, start_address,
                   register_count, output ready);
endinterface

interface mrhm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] value;
   logic [6:0]  register_index;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, kind, value, register_index, status, last, input ready);
   modport sink   (input valid, kind, value, register_index, status, last, output ready);
endinterface

[hdl/mrhm_frame_gen.sv]
module mrhm_frame_gen #(
   parameter int MAX_REPORT_BYTES = mrhm_pkg::MAX_REPORT_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 advance,
   input  logic [15:0]          start_address,
   input  logic [6:0]           register_count,
   input  logic [7:0]           slave_address,
   input  logic [7:0]           outbound_report_id,
   input  logic [6:0]           report_size,
   output mrhm_pkg::gen_out_type gen_out
);
   import mrhm_pkg::*;

   localparam int CntW = $clog2(MAX_REPORT_BYTES);

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic            busy_ff, busy_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] size_m1_ff, size_m1_in;
   logic [15:0]     crc_ff, crc_in;
   logic [15:0]     addr_ff, addr_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [6:0]      size_clamped;
   logic [7:0]      data;
   logic            in_crc;

   // report length clamped to the legal range
   always_comb begin
      if (report_size < 7'(MIN_REPORT_BYTES)) begin
         size_clamped = 7'(MIN_REPORT_BYTES);
      end else if (report_size > 7'(MAX_REPORT_BYTES)) begin
         size_clamped = 7'(MAX_REPORT_BYTES);
      end else begin
         size_clamped = report_size;
      end
      size_m1_in = CntW'(size_clamped - 7'd1);
   end

   always_comb begin
      unique case (idx_ff)
         CntW'(0): data = outbound_report_id;
         CntW'(1): data = slave_address;
         CntW'(2): data = FN_READ_HOLDING;
         CntW'(3): data = addr_ff[15:8];
         CntW'(4): data = addr_ff[7:0];
         CntW'(5): data = 8'd0;
         CntW'(6): data = {1'b0, cnt_ff};
         CntW'(7): data = crc_ff[7:0];
         CntW'(8): data = crc_ff[15:8];
         default:  data = 8'd0;
      endcase
      in_crc = (idx_ff >= CntW'(1)) && (idx_ff <= CntW'(6));
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         crc_in  = CRC_INIT;
         addr_in = start_address;
         cnt_in  = register_count;
      end else if (busy_ff && advance) begin
         idx_in = idx_ff + CntW'(1);
         if (in_crc) begin
            crc_in = crc_update(crc_ff, data);
         end
         if (idx_ff == size_m1_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      crc_ff  <= crc_in;
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      if (load) begin
         size_m1_ff <= size_m1_in;
      end
   end

   assign gen_out.busy = busy_ff;
   assign gen_out.data = data;
   assign gen_out.last = (idx_ff == size_m1_ff);

endmodule

[hdl/mrhm_rsp_parse.sv]
module mrhm_rsp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [6:0]             register_count,
   input  logic                   step,
   input  logic                   first_of_report,
   input  logic [7:0]             data_byte,
   input  logic [7:0]             slave_address,
   input  logic [7:0]             inbound_report_id,
   output mrhm_pkg::parse_out_type parse_out
);
   import mrhm_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_DONE} phase_type;

   phase_type  phase_ff, phase_in;
   logic [8:0] pos_ff, pos_in;
   logic [6:0] req_ff, req_in;
   logic [7:0] slave_ff, slave_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] high_ff, high_in;
   logic       drop_ff, drop_in;
   logic [8:0] d;
   logic [7:0] idx8;
   logic       hit;

   always_comb begin
      d    = pos_ff - 9'd3;
      idx8 = d[8:1];
      hit  = step && (phase_ff == PH_WAIT) && !first_of_report && !drop_ff;

      phase_in = phase_ff;
      pos_in   = pos_ff;
      req_in   = req_ff;
      slave_in = slave_ff;
      func_in  = func_ff;
      high_in  = high_ff;
      drop_in  = drop_ff;
      parse_out = '{word: 1'b0, word_value: {high_ff, data_byte},
                    word_index: idx8[6:0], done: 1'b0, done_status: STATUS_OK,
                    done_value: 16'd0};

      if (start) begin
         phase_in = PH_WAIT;
         pos_in   = '0;
         req_in   = register_count;
         slave_in = '0;
         func_in  = '0;
         high_in  = '0;
         drop_in  = 1'b1;
      end else if (step && (phase_ff == PH_WAIT) && first_of_report) begin
         drop_in = (data_byte != inbound_report_id);
      end else if (hit) begin
         pos_in = pos_ff + 9'd1;
         priority if (pos_ff == 9'd0) begin
            slave_in = data_byte;
         end else if (pos_ff == 9'd1) begin
            func_in = data_byte;
         end else if (pos_ff == 9'd2) begin
            // checks in order: exception, slave/function, byte count
            priority if (func_ff[EXCEPTION_BIT]) begin
               parse_out.done        = 1'b1;
               parse_out.done_status = STATUS_EXCEPTION;
               parse_out.done_value  = {8'd0, data_byte};
            end else if (slave_ff != slave_address || func_ff != FN_READ_HOLDING) begin
               parse_out.done        = 1'b1;
               parse_out.done_status = STATUS_WRONG_ID;
            end else if (data_byte != {req_ff, 1'b0}) begin
               parse_out.done        = 1'b1;
               parse_out.done_status = STATUS_COUNT_BAD;
            end else if (req_ff == 7'd0) begin
               parse_out.done = 1'b1;
            end else begin
               parse_out.done = 1'b0;
            end
         end else begin
            if (!d[0]) begin
               high_in = data_byte;
            end else begin
               parse_out.word = 1'b1;
               parse_out.done = ({1'b0, idx8} + 9'd1) >= {2'b0, req_ff};
            end
         end
         if (parse_out.done) begin
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         req_ff   <= '0;
         slave_ff <= '0;
         func_ff  <= '0;
         high_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         req_ff   <= req_in;
         slave_ff <= slave_in;
         func_ff  <= func_in;
         high_ff  <= high_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

[hdl/modbus_read_holding_master.sv]
// Modbus "read holding registers" master carried in fixed-size reports. A start item
// (command 0) emits one outbound report, one byte item per cycle while the output
// register is free: report ID, slave, function 3, address and count big-endian,
// CRC-16 low byte first, then zeros up to report_size (clamped to 9..MAX_REPORT_BYTES).
// Received report bytes (command 1) are taken one per cycle while no report is being
// sent, no completion is owed and the output register is free; register words stream
// out as their low byte lands and a completion item (last set) closes the transaction,
// or reports an exception, wrong slave/function or byte-count mismatch at the third
// payload byte. A start always aborts a transaction in progress. The byte that brings
// the final register word also owes a completion, emitted after the word, as the two
// share the single output register. While the outbound byte sequencer paces a report,
// further items wait in the input register. CSR writes are only legal while the block
// is idle.
`include "assert_macros.svh"

module modbus_read_holding_master #(
   parameter int MAX_REPORT_BYTES = mrhm_pkg::MAX_REPORT_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [mrhm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mrhm_pkg::CSR_DATA_W-1:0]  csr_write_data,
   mrhm_req_if.sink                         req,
   mrhm_rsp_if.source                       rsp
);
   import mrhm_pkg::*;

   // configuration registers
   logic [7:0] slave_address_ff;
   logic [7:0] outbound_report_id_ff;
   logic [7:0] inbound_report_id_ff;
   logic [6:0] report_size_ff;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   // completion owed after a final register word
   logic pend_ff, pend_in;

   gen_out_type   gen_st;
   parse_out_type parse_st;
   rsp_item_type  emit_item;
   logic          emit;
   logic          out_free;
   logic          busy;
   logic          consume;
   logic          load;
   logic          step;
   logic          done_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff      <= SLAVE_ADDRESS_RST;
         outbound_report_id_ff <= OUTBOUND_REPORT_ID_RST;
         inbound_report_id_ff  <= INBOUND_REPORT_ID_RST;
         report_size_ff        <= REPORT_SIZE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:      slave_address_ff      <= csr_write_data;
            CSR_OUTBOUND_REPORT_ID: outbound_report_id_ff <= csr_write_data;
            CSR_INBOUND_REPORT_ID:  inbound_report_id_ff  <= csr_write_data;
            CSR_REPORT_SIZE:        report_size_ff        <= csr_write_data[6:0];
         endcase
      end
   end

   // handshake and dispatch
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign busy      = gen_st.busy || pend_ff;
   assign consume   = in_valid_ff && !busy && out_free;
   assign load      = consume && (in_item_ff.command == CMD_START);
   assign step      = consume && (in_item_ff.command == CMD_BYTE);
   assign req.ready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   mrhm_frame_gen #(
      .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
   ) u_frame_gen (
      .clock              (clock),
      .reset              (reset),
      .load               (load),
      .advance            (out_free),
      .start_address      (in_item_ff.start_address),
      .register_count     (in_item_ff.register_count),
      .slave_address      (slave_address_ff),
      .outbound_report_id (outbound_report_id_ff),
      .report_size        (report_size_ff),
      .gen_out            (gen_st)
   );

   mrhm_rsp_parse u_rsp_parse (
      .clock             (clock),
      .reset             (reset),
      .start             (load),
      .register_count    (in_item_ff.register_count),
      .step              (step),
      .first_of_report   (in_item_ff.first_of_report),
      .data_byte         (in_item_ff.data_byte),
      .slave_address     (slave_address_ff),
      .inbound_report_id (inbound_report_id_ff),
      .parse_out         (parse_st)
   );

   // pick the item for the output register: outbound bytes, then an owed
   // completion, then whatever the current received byte produced
   always_comb begin
      emit    = 1'b0;
      pend_in = pend_ff;
      emit_item = '{kind: KIND_COMPLETE, value: 16'd0, register_index: 7'd0,
                    status: STATUS_OK, last: 1'b1};
      if (gen_st.busy) begin
         emit = out_free;
         emit_item = '{kind: KIND_OUT_BYTE, value: {8'd0, gen_st.data},
                       register_index: 7'd0, status: STATUS_OK, last: gen_st.last};
      end else if (pend_ff) begin
         emit = out_free;
         if (out_free) begin
            pend_in = 1'b0;
         end
      end else if (step) begin
         if (parse_st.word) begin
            emit    = 1'b1;
            pend_in = parse_st.done;
            emit_item = '{kind: KIND_REG_WORD, value: parse_st.word_value,
                          register_index: parse_st.word_index, status: STATUS_OK,
                          last: 1'b0};
         end else if (parse_st.done) begin
            emit = 1'b1;
            emit_item = '{kind: KIND_COMPLETE, value: parse_st.done_value,
                          register_index: 7'd0, status: parse_st.done_status,
                          last: 1'b1};
         end
      end
   end

   assign rsp_valid_in = out_free ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      if (req.valid && req.ready) begin
         in_item_ff <= '{command: req.command, first_of_report: req.first_of_report,
                         data_byte: req.data_byte, start_address: req.start_address,
                         register_count: req.register_count};
      end
      if (out_free && emit) begin
         rsp_item_ff <= emit_item;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_item_ff.kind;
   assign rsp.value          = rsp_item_ff.value;
   assign rsp.register_index = rsp_item_ff.register_index;
   assign rsp.status         = rsp_item_ff.status;
   assign rsp.last           = rsp_item_ff.last;

   // a completion item sits in the output register
   assign done_out = rsp_valid_ff && (rsp_item_ff.kind == KIND_COMPLETE);

   `MRHM_ASSERT_NEVER(a_gen_and_pend, clock, reset, gen_st.busy && pend_ff)
   `MRHM_ASSERT_NEXT(a_load_starts_gen, clock, reset, load, gen_st.busy)
   `MRHM_ASSERT_NEXT(a_pend_gives_done, clock, reset, pend_ff && out_free, done_out)
   `MRHM_ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !consume, in_valid_ff)

endmodule

[verif/tb.sv]
module tb;
   import mrhm_pkg::*;

   // predictor's view of the transaction
   typedef enum logic [1:0] {
      LINK_IDLE = 2'd0,
      LINK_WAIT = 2'd1,
      LINK_DONE = 2'd2
   } link_phase_type;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT      = 50000;
   localparam int SETTLE_CYCLES    = 12;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 30;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   mrhm_req_if req_ch ();
   mrhm_rsp_if rsp_ch ();

   modbus_read_holding_master i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   // items waiting to be offered, and results the block still owes us
   req_item_type req_backlog[$];
   rsp_item_type awaited_rsp[$];

   int  mismatch_count     = 0;
   int  queued_total       = 0;
   int  sender_idle_pct    = 0;
   int  receiver_stall_pct = 0;
   bit  hold_armed         = 1'b0;
   int  hold_cycles        = 0;
   logic req_taken;

   // shadow of the CSRs, updated on the same edge the block takes the write
   logic [7:0] cfg_slave;
   logic [7:0] cfg_out_id;
   logic [7:0] cfg_in_id;
   logic [6:0] cfg_report_size;

   // shadow of the transaction state
   link_phase_type link_phase;
   logic [8:0]     payload_pos;
   logic [6:0]     want_count;
   logic [7:0]     slave_seen;
   logic [7:0]     fn_seen;
   logic [7:0]     byte_count_seen;
   logic [7:0]     word_high;
   logic           dropping;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   function automatic void reset_shadow();
      cfg_slave       = SLAVE_ADDRESS_RST;
      cfg_out_id      = OUTBOUND_REPORT_ID_RST;
      cfg_in_id       = INBOUND_REPORT_ID_RST;
      cfg_report_size = REPORT_SIZE_RST;
      link_phase      = LINK_IDLE;
      payload_pos     = '0;
      want_count      = '0;
      slave_seen      = '0;
      fn_seen         = '0;
      byte_count_seen = '0;
      word_high       = '0;
      dropping        = 1'b0;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [7:0] data);
      case (csr_index_type'(idx))
         CSR_SLAVE_ADDRESS:      cfg_slave       = data;
         CSR_OUTBOUND_REPORT_ID: cfg_out_id      = data;
         CSR_INBOUND_REPORT_ID:  cfg_in_id       = data;
         CSR_REPORT_SIZE:        cfg_report_size = data[6:0];
         default: ;
      endcase
   endfunction

   // Modbus CRC-16, reflected, one byte at a time
   function automatic logic [15:0] crc16_modbus(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic void owe_result(kind_type k, logic [15:0] v, logic [6:0] idx,
                                      status_type st, logic lst);
      awaited_rsp.push_back(rsp_item_type'{kind: k, value: v, register_index: idx,
                                           status: st, last: lst});
   endfunction

   function automatic void close_exchange(status_type st, logic [15:0] v);
      owe_result(KIND_COMPLETE, v, 7'd0, st, 1'b1);
      link_phase = LINK_DONE;
   endfunction

   // works out what one accepted item makes the master emit
   function automatic void derive_responses(req_item_type it);
      logic [7:0]  frame [8];
      logic [15:0] crc;
      logic [7:0]  b;
      logic [8:0]  pos;
      int          size;
      int          d;
      int          idx;

      if (it.command == CMD_START) begin
         size = int'(cfg_report_size);
         if (size < MIN_REPORT_BYTES)     size = MIN_REPORT_BYTES;
         if (size > MAX_REPORT_BYTES_DEF) size = MAX_REPORT_BYTES_DEF;
         frame[0] = cfg_slave;
         frame[1] = FN_READ_HOLDING;
         frame[2] = it.start_address[15:8];
         frame[3] = it.start_address[7:0];
         frame[4] = 8'h00;
         frame[5] = {1'b0, it.register_count};
         crc = CRC_INIT;
         for (int i = 0; i < 6; i++)
            crc = crc16_modbus(crc, frame[i]);
         frame[6] = crc[7:0];
         frame[7] = crc[15:8];
         for (int i = 0; i < size; i++) begin
            if (i == 0)      b = cfg_out_id;
            else if (i <= 8) b = frame[i-1];
            else             b = 8'h00;
            owe_result(KIND_OUT_BYTE, {8'h00, b}, 7'd0, STATUS_OK, i == size - 1);
         end
         // a start always throws away whatever was in progress
         link_phase      = LINK_WAIT;
         payload_pos     = '0;
         want_count      = it.register_count;
         slave_seen      = '0;
         fn_seen         = '0;
         byte_count_seen = '0;
         word_high       = '0;
         dropping        = 1'b1;
         return;
      end

      b = it.data_byte;
      if (link_phase != LINK_WAIT) return;
      if (it.first_of_report) begin
         dropping = (b != cfg_in_id);
         return;
      end
      if (dropping) return;

      pos         = payload_pos;
      payload_pos = pos + 9'd1;

      if (pos == 9'd0) begin
         slave_seen = b;
      end else if (pos == 9'd1) begin
         fn_seen = b;
      end else if (pos == 9'd2) begin
         byte_count_seen = b;
         if (fn_seen[EXCEPTION_BIT])
            close_exchange(STATUS_EXCEPTION, {8'h00, b});
         else if (slave_seen != cfg_slave || fn_seen != FN_READ_HOLDING)
            close_exchange(STATUS_WRONG_ID, 16'h0000);
         else if (int'(b) != 2 * int'(want_count))
            close_exchange(STATUS_COUNT_BAD, 16'h0000);
         else if (want_count == 7'd0)
            close_exchange(STATUS_OK, 16'h0000);
      end else begin
         d   = int'(pos) - 3;
         idx = d >> 1;
         if ((d & 1) == 0) begin
            word_high = b;
         end else begin
            owe_result(KIND_REG_WORD, {word_high, b}, 7'(idx), STATUS_OK, 1'b0);
            if (idx + 1 >= int'(want_count))
               close_exchange(STATUS_OK, 16'h0000);
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offers the backlog on the falling edge, holds an item until taken
   // -------------------------------------------------------------------------

   always @(negedge clock) begin
      req_item_type nxt;
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt = req_backlog.pop_front();
            req_ch.valid           <= 1'b1;
            req_ch.command         <= nxt.command;
            req_ch.first_of_report <= nxt.first_of_report;
            req_ch.data_byte       <= nxt.data_byte;
            req_ch.start_address   <= nxt.start_address;
            req_ch.register_count  <= nxt.register_count;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off so the input backs up
   always @(negedge clock) begin
      if (hold_armed && hold_cycles < LONG_HOLD_CYCLES) begin
         hold_cycles  <= hold_cycles + 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: everything sampled on the rising edge
   // -------------------------------------------------------------------------

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      req_item_type seen;
      if (reset) begin
         req_taken <= 1'b0;
         reset_shadow();
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (csr_write_enable)
            apply_csr(csr_index, csr_write_data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("result item with nothing outstanding: kind %0d value %0h",
                      rsp_ch.kind, rsp_ch.value);
               mismatch_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_ch.kind));
               check_field("value", want.value, rsp_ch.value);
               check_field("register_index", 16'(want.register_index),
                           16'(rsp_ch.register_index));
               check_field("status", 16'(want.status), 16'(rsp_ch.status));
               check_field("last", 16'(want.last), 16'(rsp_ch.last));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen = {req_ch.command, req_ch.first_of_report, req_ch.data_byte,
                    req_ch.start_address, req_ch.register_count};
            derive_responses(seen);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // unused fields of each item carry random junk
   task automatic queue_start(logic [15:0] addr, logic [6:0] cnt);
      req_item_type it;
      it.command         = CMD_START;
      it.first_of_report = 1'($urandom_range(1));
      it.data_byte       = 8'($urandom);
      it.start_address   = addr;
      it.register_count  = cnt;
      req_backlog.push_back(it);
      queued_total++;
   endtask

   task automatic queue_rx(logic first, logic [7:0] b);
      req_item_type it;
      it.command         = CMD_BYTE;
      it.first_of_report = first;
      it.data_byte       = b;
      it.start_address   = 16'($urandom);
      it.register_count  = 7'($urandom);
      req_backlog.push_back(it);
      queued_total++;
   endtask

   function automatic logic [7:0] foreign_id();
      return cfg_in_id ^ 8'($urandom_range(1, 255));
   endfunction

   // one request/response exchange, mostly well formed, sometimes broken
   task automatic queue_random_exchange();
      logic [7:0] payload[$];
      int pick;
      int cnt;
      int flaw;
      int stop_at;
      int fn;

      pick = $urandom_range(99);
      if (pick < 6) begin
         // stray bytes: ignored or restarting report framing
         repeat ($urandom_range(1, 4))
            queue_rx(1'($urandom_range(1)), 8'($urandom));
         return;
      end
      if (pick < 88)      cnt = $urandom_range(0, 6);
      else if (pick < 95) cnt = $urandom_range(7, 16);
      else                cnt = $urandom_range(17, 127);
      queue_start(16'($urandom), 7'(cnt));

      payload.push_back(cfg_slave);
      payload.push_back(FN_READ_HOLDING);
      payload.push_back(8'(2 * cnt));
      repeat (2 * cnt) payload.push_back(8'($urandom));

      flaw = $urandom_range(99);
      if (flaw < 10) begin
         payload[1] = 8'h80 | 8'($urandom_range(0, 127));
         payload[2] = 8'($urandom);
      end else if (flaw < 16) begin
         payload[0] = cfg_slave ^ 8'($urandom_range(1, 255));
      end else if (flaw < 22) begin
         fn = $urandom_range(0, 126);
         if (fn >= int'(FN_READ_HOLDING)) fn++;
         payload[1] = 8'(fn);
      end else if (flaw < 28) begin
         payload[2] = 8'(2 * cnt + $urandom_range(1, 255));
      end

      // big counts and a few others get cut short by the next start
      stop_at = payload.size();
      if (cnt > 16 || flaw >= 92) begin
         stop_at = $urandom_range(0, payload.size() - 1);
         if (stop_at > 20) stop_at = $urandom_range(0, 20);
      end

      // bytes before any valid report ID are dropped
      if ($urandom_range(9) == 0) queue_rx(1'b0, 8'($urandom));
      if ($urandom_range(9) == 0) begin
         queue_rx(1'b1, foreign_id());
         queue_rx(1'b0, 8'($urandom));
      end
      queue_rx(1'b1, cfg_in_id);
      for (int i = 0; i < stop_at; i++) begin
         // response spread over several reports, with a foreign one in between
         if (i > 0 && $urandom_range(11) == 0) begin
            if ($urandom_range(2) == 0) begin
               queue_rx(1'b1, foreign_id());
               repeat ($urandom_range(1, 3)) queue_rx(1'b0, 8'($urandom));
            end
            queue_rx(1'b1, cfg_in_id);
         end
         queue_rx(1'b0, payload[i]);
      end
      // trailing bytes land in the done phase unless the exchange was cut short
      if ($urandom_range(7) == 0) queue_rx(1'($urandom_range(1)), 8'($urandom));
   endtask

   // waits until the backlog is offered and every owed result has come back
   task automatic settle();
      int waited;
      waited = 0;
      while ((req_backlog.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      // a trailing byte may still sit in the input register
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (awaited_rsp.size() != 0) begin
         $error("%0d result items never arrived", awaited_rsp.size());
         mismatch_count++;
         awaited_rsp.delete();
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
         default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------

   initial begin
      logic [7:0] sl;
      logic [7:0] oi;
      logic [7:0] ii;
      logic [7:0] rs;
      int         goal;

      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = CSR_SLAVE_ADDRESS;
      csr_write_data         = '0;
      req_ch.valid           = 1'b0;
      req_ch.command         = CMD_START;
      req_ch.first_of_report = 1'b0;
      req_ch.data_byte       = '0;
      req_ch.start_address   = '0;
      req_ch.register_count  = '0;
      rsp_ch.ready           = 1'b0;
      reset_shadow();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset settings, no idling.
      set_idling(0);
      // byte while idle: ignored
      queue_rx(1'b1, INBOUND_REPORT_ID_RST);
      // zero registers, lowest address: completes ok on the count byte
      queue_start(16'h0000, 7'd0);
      queue_rx(1'b1, INBOUND_REPORT_ID_RST);
      queue_rx(1'b0, SLAVE_ADDRESS_RST);
      queue_rx(1'b0, FN_READ_HOLDING);
      queue_rx(1'b0, 8'h00);
      // byte after completion: ignored
      queue_rx(1'b0, 8'hA5);
      // top address, largest count; stray byte and foreign report dropped first
      queue_start(16'hFFFF, 7'd127);
      queue_rx(1'b0, 8'h55);
      queue_rx(1'b1, 8'h00);
      queue_rx(1'b1, INBOUND_REPORT_ID_RST);
      queue_rx(1'b0, SLAVE_ADDRESS_RST);
      queue_rx(1'b0, FN_READ_HOLDING);
      queue_rx(1'b0, 8'hFE);
      queue_rx(1'b0, 8'hFF);
      queue_rx(1'b0, 8'h00);
      // start mid-response aborts; slave answers with an exception
      queue_start(16'h1234, 7'd1);
      queue_rx(1'b1, INBOUND_REPORT_ID_RST);
      queue_rx(1'b0, SLAVE_ADDRESS_RST);
      queue_rx(1'b0, 8'h83);
      queue_rx(1'b0, 8'h0B);
      // answer from the wrong slave
      queue_start(16'h8001, 7'd1);
      queue_rx(1'b1, INBOUND_REPORT_ID_RST);
      queue_rx(1'b0, 8'h02);
      queue_rx(1'b0, FN_READ_HOLDING);
      queue_rx(1'b0, 8'h02);
      settle();

      // Random phases: new CSR settings each time, extremes first.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         sl = 8'($urandom);
         oi = 8'($urandom);
         ii = 8'($urandom);
         case (ph)
            0: begin sl = 8'h00; oi = 8'h00; ii = 8'h00; rs = 8'd9; end
            1: begin sl = 8'hFF; oi = 8'hFF; ii = 8'hFF; rs = 8'd64; end
            2: rs = 8'd0;      // clamps up to the minimum
            3: rs = 8'h7F;     // clamps down to the maximum
            4: rs = 8'hC5;     // top bit is not part of the register
            default: rs = 8'($urandom);
         endcase
         write_csr(CSR_SLAVE_ADDRESS, sl);
         write_csr(CSR_OUTBOUND_REPORT_ID, oi);
         write_csr(CSR_INBOUND_REPORT_ID, ii);
         write_csr(CSR_REPORT_SIZE, rs);
         @(negedge clock);
         csr_write_enable <= 1'b0;
         @(negedge clock);

         set_idling(ph % 4);
         // receiver sits still while the sender keeps pushing
         if (ph == 4) hold_armed = 1'b1;
         goal = queued_total + ITEMS_PER_PHASE;
         while (queued_total < goal) queue_random_exchange();
         settle();
      end

      if (mismatch_count == 0) begin
         $display("PASS modbus_read_holding_master");
      end else begin
         $display("FAIL modbus_read_holding_master");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("FAIL modbus_read_holding_master");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/mrhm_pkg.sv
hdl/mrhm_ifs.sv
hdl/mrhm_frame_gen.sv
hdl/mrhm_rsp_parse.sv
hdl/modbus_read_holding_master.sv
verif/tb.sv
